// File: rtl/rc_arming_failsafe_controller_unit_macros.svh
// assertion helpers for the arming and failsafe controller
`ifndef RC_ARMING_FAILSAFE_CONTROLLER_UNIT_MACROS_SVH
`define RC_ARMING_FAILSAFE_CONTROLLER_UNIT_MACROS_SVH

// checked outside reset only
`define RAFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RAFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rafc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rafc_pkg;

  localparam int unsigned TICK_MS_DEFAULT        = 20;
  localparam int unsigned ARM_HOLD_MS_DEFAULT    = 1000;
  localparam int unsigned LINK_OFFSET_US_DEFAULT = 150;
  localparam int unsigned HYST_LIMIT_DEFAULT     = 10;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int PULSE_W    = 12;
  localparam int LEVEL_W    = 16;
  localparam int COUNT_W    = 8;
  localparam int ELAPSED_W  = 17;

  localparam logic [ELAPSED_W-1:0]      ELAPSED_MAX   = '1;
  localparam logic signed [LEVEL_W-1:0] SWITCH_TH     = 16'sd10923;
  localparam logic signed [LEVEL_W:0]   STICK_TH      = 17'sd29492;
  localparam logic signed [LEVEL_W-1:0] THR_FAILSAFE  = 16'sh8000;

  // register indexes (word address)
  localparam logic [2:0] REG_PULSE_MAX   = 3'd0;
  localparam logic [2:0] REG_PULSE_MIN   = 3'd1;
  localparam logic [2:0] REG_ARMING_MODE = 3'd2;
  localparam logic [2:0] REG_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_POS1_MODE   = 3'd4;
  localparam logic [2:0] REG_POS2_MODE   = 3'd5;
  localparam logic [2:0] REG_POS3_MODE   = 3'd6;

  localparam logic [1:0] MODE_MANUAL     = 2'd0;
  localparam logic [1:0] MODE_STABILIZED = 2'd1;
  localparam logic [1:0] MODE_AUTO       = 2'd2;

  // arming mode codes
  localparam logic [1:0] ARM_ON_LOW_THROTTLE = 2'd0;
  localparam logic [1:0] ARM_STICK           = 2'd1;
  localparam logic [1:0] ARM_STICK_REVERSED  = 2'd2;

  typedef enum logic [2:0] {
    PH_DISARMED   = 3'd0,
    PH_ARMING     = 3'd1,
    PH_ARMED      = 3'd2,
    PH_DISARM_MAN = 3'd3,
    PH_DISARM_TMO = 3'd4
  } arm_phase_t;

  typedef struct packed {
    logic [PULSE_W-1:0] throttle_pulse_max;
    logic [PULSE_W-1:0] throttle_pulse_min;
    logic [1:0]         arming_mode;
    logic [15:0]        armed_timeout_ms;
    logic [1:0]         pos1_flight_mode;
    logic [1:0]         pos2_flight_mode;
    logic [1:0]         pos3_flight_mode;
  } cfg_t;

  typedef struct packed {
    logic                      link_connected;
    logic                      armed_flag;
    logic [1:0]                flight_mode;
    arm_phase_t                arm_phase;
    logic signed [LEVEL_W-1:0] throttle_out;
    logic                      link_warning;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/rafc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rafc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rafc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [rafc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [rafc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output rafc_pkg::cfg_t                        cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[rafc_pkg::APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throttle_pulse_max <= 12'd2000;
      cfg.throttle_pulse_min <= 12'd1000;
      cfg.arming_mode        <= rafc_pkg::ARM_ON_LOW_THROTTLE;
      cfg.armed_timeout_ms   <= 16'd0;
      cfg.pos1_flight_mode   <= rafc_pkg::MODE_MANUAL;
      cfg.pos2_flight_mode   <= rafc_pkg::MODE_STABILIZED;
      cfg.pos3_flight_mode   <= rafc_pkg::MODE_AUTO;
    end else if (wr_en) begin
      unique case (index)
        rafc_pkg::REG_PULSE_MAX:   cfg.throttle_pulse_max <= pwdata[11:0];
        rafc_pkg::REG_PULSE_MIN:   cfg.throttle_pulse_min <= pwdata[11:0];
        rafc_pkg::REG_ARMING_MODE: cfg.arming_mode        <= pwdata[1:0];
        rafc_pkg::REG_TIMEOUT:     cfg.armed_timeout_ms   <= pwdata[15:0];
        rafc_pkg::REG_POS1_MODE:   cfg.pos1_flight_mode   <= pwdata[1:0];
        rafc_pkg::REG_POS2_MODE:   cfg.pos2_flight_mode   <= pwdata[1:0];
        rafc_pkg::REG_POS3_MODE:   cfg.pos3_flight_mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      rafc_pkg::REG_PULSE_MAX:   prdata = 32'(cfg.throttle_pulse_max);
      rafc_pkg::REG_PULSE_MIN:   prdata = 32'(cfg.throttle_pulse_min);
      rafc_pkg::REG_ARMING_MODE: prdata = 32'(cfg.arming_mode);
      rafc_pkg::REG_TIMEOUT:     prdata = 32'(cfg.armed_timeout_ms);
      rafc_pkg::REG_POS1_MODE:   prdata = 32'(cfg.pos1_flight_mode);
      rafc_pkg::REG_POS2_MODE:   prdata = 32'(cfg.pos2_flight_mode);
      rafc_pkg::REG_POS3_MODE:   prdata = 32'(cfg.pos3_flight_mode);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rafc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rafc_core #(
  parameter int unsigned TICK_MS        = rafc_pkg::TICK_MS_DEFAULT,
  parameter int unsigned ARM_HOLD_MS    = rafc_pkg::ARM_HOLD_MS_DEFAULT,
  parameter int unsigned LINK_OFFSET_US = rafc_pkg::LINK_OFFSET_US_DEFAULT,
  parameter int unsigned HYST_LIMIT     = rafc_pkg::HYST_LIMIT_DEFAULT
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      step,
  input  wire rafc_pkg::cfg_t                            cfg,
  input  wire logic        [rafc_pkg::PULSE_W-1:0]       throttle_pulse,
  input  wire logic signed [rafc_pkg::LEVEL_W-1:0]       throttle_level,
  input  wire logic signed [rafc_pkg::LEVEL_W-1:0]       arm_stick_level,
  input  wire logic signed [rafc_pkg::LEVEL_W-1:0]       mode_switch_level,
  output rafc_pkg::result_t                              result
);

  localparam int PW = rafc_pkg::PULSE_W;
  localparam int LW = rafc_pkg::LEVEL_W;
  localparam int CW = rafc_pkg::COUNT_W;
  localparam int EW = rafc_pkg::ELAPSED_W;

  rafc_pkg::arm_phase_t phase, phase_next;
  logic                 link_state, link_next;
  logic [CW-1:0]        good_count, good_next;
  logic [CW-1:0]        lost_count, lost_next;
  logic [EW-1:0]        elapsed, elapsed_next;
  logic                 armed, armed_next;

  logic [EW:0]             elapsed_sum;
  logic [EW-1:0]           elapsed_tick;
  logic signed [PW:0]      max_lim;
  logic signed [PW:0]      min_lim;
  logic signed [PW:0]      pulse_s;
  logic                    tick_lost;
  logic signed [LW-1:0]    thr;
  logic signed [LW:0]      stick_ext;
  logic signed [LW:0]      lv;
  logic                    want_arm;
  logic                    want_disarm;
  logic [1:0]              mode_sel;
  logic [1:0]              mode;

  always_comb begin
    elapsed_sum  = {1'b0, elapsed} + (EW+1)'(TICK_MS);
    elapsed_tick = (elapsed_sum > {1'b0, rafc_pkg::ELAPSED_MAX}) ?
                   rafc_pkg::ELAPSED_MAX : elapsed_sum[EW-1:0];

    // switch decode
    if (mode_switch_level <= -rafc_pkg::SWITCH_TH) begin
      mode_sel = cfg.pos1_flight_mode;
    end else if (mode_switch_level >= rafc_pkg::SWITCH_TH) begin
      mode_sel = cfg.pos3_flight_mode;
    end else begin
      mode_sel = cfg.pos2_flight_mode;
    end
    mode = (mode_sel > rafc_pkg::MODE_AUTO) ? rafc_pkg::MODE_AUTO : mode_sel;

    // link hysteresis
    max_lim   = (PW+1)'(cfg.throttle_pulse_max) - (PW+1)'(LINK_OFFSET_US);
    min_lim   = (PW+1)'(cfg.throttle_pulse_min) - (PW+1)'(LINK_OFFSET_US);
    pulse_s   = $signed({1'b0, throttle_pulse});
    tick_lost = (pulse_s < max_lim) && (pulse_s < min_lim);

    link_next = link_state;
    good_next = good_count;
    lost_next = lost_count;
    if (tick_lost) begin
      if (lost_count > CW'(HYST_LIMIT)) begin
        link_next = 1'b0;
        good_next = '0;
        lost_next = '0;
      end else begin
        lost_next = lost_count + CW'(2);
      end
    end else begin
      if (good_count > CW'(HYST_LIMIT)) begin
        link_next = 1'b1;
        good_next = '0;
        lost_next = '0;
      end else begin
        good_next = good_count + CW'(2);
      end
    end

    thr = link_next ? throttle_level : rafc_pkg::THR_FAILSAFE;

    // stick requests, reversal without saturation
    stick_ext   = {arm_stick_level[LW-1], arm_stick_level};
    lv          = cfg.arming_mode[1] ? -stick_ext : stick_ext;
    want_arm    = link_next && (lv <= -rafc_pkg::STICK_TH);
    want_disarm = link_next && !(lv <= -rafc_pkg::STICK_TH) && (lv >= rafc_pkg::STICK_TH);

    phase_next   = phase;
    armed_next   = armed;
    elapsed_next = elapsed_tick;
    if (thr[LW-1]) begin
      if (cfg.arming_mode == rafc_pkg::ARM_ON_LOW_THROTTLE) begin
        armed_next = 1'b1;
      end else begin
        unique case (phase)
          rafc_pkg::PH_ARMING: begin
            if (!want_arm) begin
              phase_next = rafc_pkg::PH_DISARMED;
            end else if (elapsed_tick > EW'(ARM_HOLD_MS)) begin
              phase_next = rafc_pkg::PH_ARMED;
            end
          end
          rafc_pkg::PH_ARMED: begin
            elapsed_next = '0;
            phase_next   = rafc_pkg::PH_DISARM_TMO;
            armed_next   = 1'b1;
          end
          rafc_pkg::PH_DISARM_TMO: begin
            if (cfg.armed_timeout_ms != 16'd0 &&
                elapsed_tick > {1'b0, cfg.armed_timeout_ms}) begin
              phase_next = rafc_pkg::PH_DISARMED;
            end
            if (want_disarm) begin
              elapsed_next = '0;
              phase_next   = rafc_pkg::PH_DISARM_MAN;
            end
          end
          rafc_pkg::PH_DISARM_MAN: begin
            if (!want_disarm) begin
              phase_next = rafc_pkg::PH_ARMED;
            end else if (elapsed_tick > EW'(ARM_HOLD_MS)) begin
              phase_next = rafc_pkg::PH_DISARMED;
            end
          end
          default: begin
            phase_next = rafc_pkg::PH_DISARMED;
            armed_next = 1'b0;
            if (want_arm) begin
              elapsed_next = '0;
              phase_next   = rafc_pkg::PH_ARMING;
            end
          end
        endcase
      end
    end else begin
      if (phase == rafc_pkg::PH_DISARM_MAN || phase == rafc_pkg::PH_DISARM_TMO) begin
        phase_next = rafc_pkg::PH_ARMED;
      end else if (phase == rafc_pkg::PH_ARMING) begin
        phase_next = rafc_pkg::PH_DISARMED;
      end
    end

    result.link_connected = link_next;
    result.armed_flag     = armed_next;
    result.flight_mode    = mode;
    result.arm_phase      = phase_next;
    result.throttle_out   = thr;
    result.link_warning   = !link_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= rafc_pkg::PH_DISARMED;
      link_state <= 1'b0;
      good_count <= '0;
      lost_count <= '0;
      elapsed    <= '0;
      armed      <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      link_state <= link_next;
      good_count <= good_next;
      lost_count <= lost_next;
      elapsed    <= elapsed_next;
      armed      <= armed_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rc_arming_failsafe_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// rc arming and failsafe controller
// input channel: one beat per control tick (raw throttle pulse plus throttle,
//   arming stick and mode switch levels in q1.15), in_valid / in_stall
// output channel: one beat per input beat (link state, armed flag, flight
//   mode, arm phase, failsafe throttle, link warning), out_valid / out_stall
// apb port: seven registers at byte addresses 0, 4, .. 24, pready always high;
//   the user writes them only while no beat is in flight (block does not enforce)
// path from input beat to output beat: input register, then the state update
//   and result register
// throughput: one beat per cycle while out_stall is low; the per-tick state
//   update is combinational logic between the input and result registers
// reset: clears link, counters, timer, arm phase and armed flag, loads the
//   register defaults and empties both stages
// receiver stall: the result register holds its beat; one more beat waits in
//   the input register, after which in_stall rises until out_stall drops

module rc_arming_failsafe_controller_unit #(
  parameter int unsigned TICK_MS        = rafc_pkg::TICK_MS_DEFAULT,
  parameter int unsigned ARM_HOLD_MS    = rafc_pkg::ARM_HOLD_MS_DEFAULT,
  parameter int unsigned LINK_OFFSET_US = rafc_pkg::LINK_OFFSET_US_DEFAULT,
  parameter int unsigned HYST_LIMIT     = rafc_pkg::HYST_LIMIT_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic        [rafc_pkg::PULSE_W-1:0]    throttle_pulse,
  input  wire logic signed [rafc_pkg::LEVEL_W-1:0]    throttle_level,
  input  wire logic signed [rafc_pkg::LEVEL_W-1:0]    arm_stick_level,
  input  wire logic signed [rafc_pkg::LEVEL_W-1:0]    mode_switch_level,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        link_connected,
  output logic                                        armed_flag,
  output logic             [1:0]                      flight_mode,
  output logic             [2:0]                      arm_phase,
  output logic signed      [rafc_pkg::LEVEL_W-1:0]    throttle_out,
  output logic                                        link_warning,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic        [rafc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic        [rafc_pkg::APB_DATA_W-1:0] pwdata,
  output logic             [rafc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                        pready
);

  rafc_pkg::cfg_t    cfg;
  rafc_pkg::result_t result;
  rafc_pkg::result_t res_q;

  logic                                  s1_valid;
  logic        [rafc_pkg::PULSE_W-1:0]   s1_pulse;
  logic signed [rafc_pkg::LEVEL_W-1:0]   s1_throttle;
  logic signed [rafc_pkg::LEVEL_W-1:0]   s1_stick;
  logic signed [rafc_pkg::LEVEL_W-1:0]   s1_switch;
  logic                                  s1_go;
  logic                                  step;
  logic                                  in_take;

  assign s1_go    = !out_valid || !out_stall;
  assign step     = s1_valid && s1_go;
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  rafc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rafc_core #(
    .TICK_MS        (TICK_MS),
    .ARM_HOLD_MS    (ARM_HOLD_MS),
    .LINK_OFFSET_US (LINK_OFFSET_US),
    .HYST_LIMIT     (HYST_LIMIT)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .cfg               (cfg),
    .throttle_pulse    (s1_pulse),
    .throttle_level    (s1_throttle),
    .arm_stick_level   (s1_stick),
    .mode_switch_level (s1_switch),
    .result            (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_go || !s1_valid) begin
      s1_valid <= in_valid;
    end
    if (in_take) begin
      s1_pulse    <= throttle_pulse;
      s1_throttle <= throttle_level;
      s1_stick    <= arm_stick_level;
      s1_switch   <= mode_switch_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
    if (step) begin
      res_q <= result;
    end
  end

  assign link_connected = res_q.link_connected;
  assign armed_flag     = res_q.armed_flag;
  assign flight_mode    = res_q.flight_mode;
  assign arm_phase      = res_q.arm_phase;
  assign throttle_out   = res_q.throttle_out;
  assign link_warning   = res_q.link_warning;

endmodule

`default_nettype wire

// File: rtl/rafc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rc_arming_failsafe_controller_unit_macros.svh"

module rafc_chk (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                link_connected,
  input wire logic                                armed_flag,
  input wire logic        [2:0]                   arm_phase,
  input wire logic signed [rafc_pkg::LEVEL_W-1:0] throttle_out,
  input wire logic                                link_warning
);

  // output stage is empty right after reset
  `RAFC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "out_valid after reset")

  // warning is the inverse of the link state
  `RAFC_ASSERT(a_warn_link, out_valid |-> (link_warning != link_connected), "warning mismatch")

  // a lost link forces full negative throttle
  `RAFC_ASSERT(a_failsafe_thr, (out_valid && !link_connected) |-> (throttle_out == rafc_pkg::THR_FAILSAFE), "failsafe throttle")

  // disarming phases are only reached with the motors armed
  `RAFC_ASSERT(a_disarm_armed, (out_valid && (arm_phase == rafc_pkg::PH_DISARM_MAN || arm_phase == rafc_pkg::PH_DISARM_TMO)) |-> armed_flag, "disarm phase not armed")

endmodule

bind rc_arming_failsafe_controller_unit rafc_chk u_rafc_chk (.*);

`default_nettype wire

// File: bench/rc_arming_failsafe_controller_unit_test.sv
`timescale 1ns / 1ps

module rc_arming_failsafe_controller_unit_test;
  import rafc_pkg::*;

  localparam int TICK_STEP_MS   = TICK_MS_DEFAULT;
  localparam int HOLD_MS        = ARM_HOLD_MS_DEFAULT;
  localparam int LINK_MARGIN_US = LINK_OFFSET_US_DEFAULT;
  localparam int HYST_COUNT     = HYST_LIMIT_DEFAULT;
  localparam int STICK_LEVEL    = STICK_TH;
  localparam int STALL_LIMIT    = 2000;

  // codes outside the named set
  localparam logic [1:0] ARM_STICK_ALIAS     = 2'd3;
  localparam logic [1:0] MODE_RESERVED       = 2'd3;

  typedef enum int {
    SC_ARM_HOLD,
    SC_DISARM_HOLD,
    SC_REST,
    SC_THROTTLE_UP,
    SC_LINK_DROP,
    SC_NOISE
  } scenario_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid          = 1'b0;
  logic                      in_stall;
  logic [PULSE_W-1:0]        throttle_pulse    = '0;
  logic signed [LEVEL_W-1:0] throttle_level    = '0;
  logic signed [LEVEL_W-1:0] arm_stick_level   = '0;
  logic signed [LEVEL_W-1:0] mode_switch_level = '0;
  logic                      out_valid;
  logic                      out_stall         = 1'b0;
  logic                      link_connected;
  logic                      armed_flag;
  logic [1:0]                flight_mode;
  logic [2:0]                arm_phase;
  logic signed [LEVEL_W-1:0] throttle_out;
  logic                      link_warning;
  logic                      psel              = 1'b0;
  logic                      penable           = 1'b0;
  logic                      pwrite            = 1'b0;
  logic [APB_ADDR_W-1:0]     paddr             = '0;
  logic [APB_DATA_W-1:0]     pwdata            = '0;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;

  // predictor copy of registers and state
  logic [PULSE_W-1:0]   ctl_max      = 12'd2000;
  logic [PULSE_W-1:0]   ctl_min      = 12'd1000;
  logic [1:0]           ctl_arm_mode = ARM_ON_LOW_THROTTLE;
  logic [15:0]          ctl_timeout  = 16'd0;
  logic [1:0]           ctl_pos [3]  = '{MODE_MANUAL, MODE_STABILIZED, MODE_AUTO};
  arm_phase_t           ctl_phase    = PH_DISARMED;
  logic                 ctl_link     = 1'b0;
  logic [COUNT_W-1:0]   ctl_good     = '0;
  logic [COUNT_W-1:0]   ctl_lost     = '0;
  logic [ELAPSED_W-1:0] ctl_elapsed  = '0;
  logic                 ctl_armed    = 1'b0;

  result_t due_results [$];
  int      mismatches   = 0;
  int      quiet_cycles = 0;
  int      hold_cycles  = 0;
  bit      burst_mode   = 1'b0;

  rc_arming_failsafe_controller_unit u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .throttle_pulse    (throttle_pulse),
    .throttle_level    (throttle_level),
    .arm_stick_level   (arm_stick_level),
    .mode_switch_level (mode_switch_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .link_connected    (link_connected),
    .armed_flag        (armed_flag),
    .flight_mode       (flight_mode),
    .arm_phase         (arm_phase),
    .throttle_out      (throttle_out),
    .link_warning      (link_warning),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t step_controller(input logic [PULSE_W-1:0] pulse,
                                             input logic signed [LEVEL_W-1:0] thr_in,
                                             input logic signed [LEVEL_W-1:0] stick,
                                             input logic signed [LEVEL_W-1:0] sw);
    result_t r;
    int elapsed_next;
    int lv;
    logic [1:0] fm;
    logic signed [LEVEL_W-1:0] thr;
    logic lost;
    logic want_arm;
    logic want_disarm;
    elapsed_next = int'(ctl_elapsed) + TICK_STEP_MS;
    ctl_elapsed = (elapsed_next > int'(ELAPSED_MAX)) ? ELAPSED_MAX : ELAPSED_W'(elapsed_next);

    if (int'(sw) <= -int'(SWITCH_TH)) fm = ctl_pos[0];
    else if (int'(sw) >= int'(SWITCH_TH)) fm = ctl_pos[2];
    else fm = ctl_pos[1];
    if (fm > MODE_AUTO) fm = MODE_AUTO;

    lost = (int'(pulse) < int'(ctl_max) - LINK_MARGIN_US) &&
           (int'(pulse) < int'(ctl_min) - LINK_MARGIN_US);
    if (lost) begin
      if (ctl_lost > HYST_COUNT) begin
        ctl_link = 1'b0;
        ctl_good = '0;
        ctl_lost = '0;
      end else begin
        ctl_lost = ctl_lost + 8'd2;
      end
    end else begin
      if (ctl_good > HYST_COUNT) begin
        ctl_link = 1'b1;
        ctl_good = '0;
        ctl_lost = '0;
      end else begin
        ctl_good = ctl_good + 8'd2;
      end
    end

    thr = ctl_link ? thr_in : THR_FAILSAFE;

    if (thr[LEVEL_W-1]) begin
      if (ctl_arm_mode == ARM_ON_LOW_THROTTLE) begin
        ctl_armed = 1'b1;
      end else begin
        // reversal negates without saturation, so -1.0 becomes a disarm request
        lv = ctl_arm_mode[1] ? -int'(stick) : int'(stick);
        want_arm = ctl_link && (lv <= -STICK_LEVEL);
        want_disarm = ctl_link && !want_arm && (lv >= STICK_LEVEL);
        case (ctl_phase)
          PH_ARMING: begin
            if (!want_arm) ctl_phase = PH_DISARMED;
            else if (ctl_elapsed > HOLD_MS) ctl_phase = PH_ARMED;
          end
          PH_ARMED: begin
            ctl_elapsed = '0;
            ctl_phase = PH_DISARM_TMO;
            ctl_armed = 1'b1;
          end
          PH_DISARM_TMO: begin
            if (ctl_timeout != 16'd0 && ctl_elapsed > ctl_timeout) ctl_phase = PH_DISARMED;
            if (want_disarm) begin
              ctl_elapsed = '0;
              ctl_phase = PH_DISARM_MAN;
            end
          end
          PH_DISARM_MAN: begin
            if (!want_disarm) ctl_phase = PH_ARMED;
            else if (ctl_elapsed > HOLD_MS) ctl_phase = PH_DISARMED;
          end
          default: begin
            ctl_phase = PH_DISARMED;
            ctl_armed = 1'b0;
            if (want_arm) begin
              ctl_elapsed = '0;
              ctl_phase = PH_ARMING;
            end
          end
        endcase
      end
    end else begin
      if (ctl_phase == PH_DISARM_MAN || ctl_phase == PH_DISARM_TMO) ctl_phase = PH_ARMED;
      else if (ctl_phase == PH_ARMING) ctl_phase = PH_DISARMED;
    end

    r.link_connected = ctl_link;
    r.armed_flag     = ctl_armed;
    r.flight_mode    = fm;
    r.arm_phase      = ctl_phase;
    r.throttle_out   = thr;
    r.link_warning   = !ctl_link;
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual phase %h throttle %h",
                   $time, arm_phase, throttle_out);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          compare_field("link_connected", want.link_connected, link_connected);
          compare_field("armed_flag", want.armed_flag, armed_flag);
          compare_field("flight_mode", want.flight_mode, flight_mode);
          compare_field("arm_phase", want.arm_phase, arm_phase);
          compare_field("throttle_out", want.throttle_out, throttle_out);
          compare_field("link_warning", want.link_warning, link_warning);
        end
      end
      if (in_valid && !in_stall)
        due_results.push_back(step_controller(throttle_pulse, throttle_level,
                                              arm_stick_level, mode_switch_level));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t timeout: no beat for %0d cycles", $time, quiet_cycles);
        $display("FAIL rc_arming_failsafe_controller_unit");
        $finish;
      end
    end
  end

  // result side: random stall per beat, or a long hold when asked
  initial begin : result_sink
    int n;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = burst_mode ? 0 : $urandom_range(0, 14);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_tick(input logic [PULSE_W-1:0] pulse,
                           input logic signed [LEVEL_W-1:0] thr,
                           input logic signed [LEVEL_W-1:0] stick,
                           input logic signed [LEVEL_W-1:0] sw);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    throttle_pulse    <= pulse;
    throttle_level    <= thr;
    arm_stick_level   <= stick;
    mode_switch_level <= sw;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PULSE_MAX:   ctl_max = value[PULSE_W-1:0];
      REG_PULSE_MIN:   ctl_min = value[PULSE_W-1:0];
      REG_ARMING_MODE: ctl_arm_mode = value[1:0];
      REG_TIMEOUT:     ctl_timeout = value[15:0];
      REG_POS1_MODE:   ctl_pos[0] = value[1:0];
      REG_POS2_MODE:   ctl_pos[1] = value[1:0];
      REG_POS3_MODE:   ctl_pos[2] = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int pmax, input int pmin, input logic [1:0] arm_mode,
                            input int timeout_ms, input logic [1:0] m1,
                            input logic [1:0] m2, input logic [1:0] m3);
    write_reg(REG_PULSE_MAX, pmax);
    write_reg(REG_PULSE_MIN, pmin);
    write_reg(REG_ARMING_MODE, arm_mode);
    write_reg(REG_TIMEOUT, timeout_ms);
    write_reg(REG_POS1_MODE, m1);
    write_reg(REG_POS2_MODE, m2);
    write_reg(REG_POS3_MODE, m3);
  endtask

  function automatic logic [PULSE_W-1:0] link_pulse(input bit drop);
    int floor_us;
    floor_us = ((ctl_max < ctl_min) ? int'(ctl_max) : int'(ctl_min)) - LINK_MARGIN_US;
    if (drop && floor_us > 0) return PULSE_W'($urandom_range(0, floor_us - 1));
    return PULSE_W'($urandom_range((floor_us < 0) ? 0 : floor_us, 4095));
  endfunction

  // stick held past the request threshold, on the side that the mode asks for
  function automatic logic signed [LEVEL_W-1:0] held_stick(input bit toward_disarm);
    int v;
    if (toward_disarm == ctl_arm_mode[1]) v = -29492 - int'($urandom_range(0, 3276));
    else v = 29492 + int'($urandom_range(0, 3275));
    return LEVEL_W'(v);
  endfunction

  function automatic logic signed [LEVEL_W-1:0] low_throttle();
    return LEVEL_W'(-int'($urandom_range(1, 32768)));
  endfunction

  task automatic run_random_phase(input int n_items);
    int sent;
    int len;
    int pick;
    int k;
    scenario_t kind;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 3) ? SC_ARM_HOLD : (pick < 5) ? SC_DISARM_HOLD :
             (pick == 5) ? SC_REST : (pick == 6) ? SC_THROTTLE_UP :
             (pick == 7) ? SC_LINK_DROP : SC_NOISE;
      burst_mode = ($urandom_range(0, 4) == 0);
      case (kind)
        SC_ARM_HOLD, SC_DISARM_HOLD: len = $urandom_range(45, 60);
        SC_REST:                     len = $urandom_range(5, 20);
        SC_THROTTLE_UP:              len = $urandom_range(1, 6);
        SC_LINK_DROP:                len = $urandom_range(1, 10);
        default:                     len = $urandom_range(1, 8);
      endcase
      if (len > n_items - sent) len = n_items - sent;
      for (k = 0; k < len; k++) begin
        case (kind)
          SC_ARM_HOLD:
            send_tick(link_pulse(0), low_throttle(), held_stick(0), LEVEL_W'($urandom));
          SC_DISARM_HOLD:
            send_tick(link_pulse(0), low_throttle(), held_stick(1), LEVEL_W'($urandom));
          SC_REST:
            send_tick(link_pulse(0), low_throttle(),
                      LEVEL_W'(int'($urandom_range(0, 58982)) - 29491), LEVEL_W'($urandom));
          SC_THROTTLE_UP:
            send_tick(link_pulse(0), LEVEL_W'($urandom_range(0, 32767)),
                      LEVEL_W'($urandom), LEVEL_W'($urandom));
          SC_LINK_DROP:
            send_tick(link_pulse(1), LEVEL_W'($urandom), LEVEL_W'($urandom),
                      LEVEL_W'($urandom));
          default:
            send_tick(PULSE_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                      LEVEL_W'($urandom));
        endcase
      end
      sent += len;
    end
    burst_mode = 1'b0;
    wait_for_results();
  endtask

  task automatic test_link_and_switch_limits;
    set_config(2000, 1000, ARM_ON_LOW_THROTTLE, 0, MODE_MANUAL, MODE_STABILIZED, MODE_AUTO);
    send_tick(12'd0, 16'sd32767, 16'sd0, 16'sh8000);
    send_tick(12'd849, -16'sd1, 16'sd32767, -16'sd10923);
    send_tick(12'd850, 16'sd0, 16'sh8000, -16'sd10922);
    send_tick(12'd4095, 16'sh8000, 16'sd29491, 16'sd10922);
    send_tick(12'd2000, 16'sd32767, 16'sd29492, 16'sd10923);
    send_tick(12'd1850, 16'sd1, -16'sd29491, 16'sd32767);
    send_tick(12'd1000, -16'sd1, -16'sd29492, 16'sd0);
    send_tick(12'd1500, 16'sd0, 16'sd0, -16'sd1);
    send_tick(12'd1200, 16'sh8000, 16'sd0, 16'sd1);
    send_tick(12'd1700, 16'sd32767, 16'sd0, 16'sd10923);
    send_tick(12'd0, -16'sd1, 16'sd0, -16'sd10923);
    send_tick(12'd3000, 16'sd0, 16'sd0, 16'sd0);
    send_tick(12'hFFF, 16'sh7FFF, 16'sh5555, 16'shAAAA);
    send_tick(12'h555, 16'shAAAA, 16'shAAAA, 16'sh5555);
    wait_for_results();
  endtask

  task automatic test_reversed_stick;
    set_config(2000, 1000, ARM_STICK_REVERSED, 0, MODE_MANUAL, MODE_STABILIZED, MODE_AUTO);
    send_tick(12'd1500, -16'sd1, 16'sd32767, 16'sd0);
    send_tick(12'd1500, -16'sd1, 16'sd32767, 16'sd0);
    send_tick(12'd1500, -16'sd1, 16'sh8000, 16'sd0);
    send_tick(12'd1500, -16'sd1, 16'sd29492, 16'sd0);
    send_tick(12'd1500, 16'sd0, 16'sd29492, 16'sd0);
    send_tick(12'd1500, -16'sd1, -16'sd29492, 16'sd0);
    send_tick(12'd1500, 16'sh8000, 16'sd29491, 16'sd0);
    wait_for_results();
  endtask

  task automatic test_stick_arming;
    set_config(2000, 1000, ARM_STICK, 0, MODE_AUTO, MODE_MANUAL, MODE_STABILIZED);
    run_random_phase(110);
  endtask

  task automatic test_reversed_wide_window;
    set_config(4095, 0, ARM_STICK_REVERSED, 65535, MODE_STABILIZED, MODE_AUTO, MODE_MANUAL);
    run_random_phase(110);
  endtask

  task automatic test_alias_codes;
    set_config(0, 4095, ARM_STICK_ALIAS, 300, MODE_RESERVED, MODE_STABILIZED, MODE_RESERVED);
    run_random_phase(110);
  endtask

  task automatic test_short_timeout;
    set_config(1500, 2500, ARM_STICK, 1, MODE_MANUAL, MODE_STABILIZED, MODE_AUTO);
    run_random_phase(110);
  endtask

  task automatic test_arm_on_low_throttle;
    set_config(4095, 4095, ARM_ON_LOW_THROTTLE, 65535, MODE_AUTO, MODE_RESERVED, MODE_MANUAL);
    run_random_phase(40);
  endtask

  task automatic test_output_backpressure;
    int k;
    set_config(2000, 1000, ARM_STICK, 500, MODE_MANUAL, MODE_STABILIZED, MODE_AUTO);
    hold_cycles = 300;
    burst_mode = 1'b1;
    for (k = 0; k < 20; k++)
      send_tick(link_pulse(k % 5 == 4), low_throttle(), held_stick(0), LEVEL_W'($urandom));
    burst_mode = 1'b0;
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_link_and_switch_limits();
    test_reversed_stick();
    test_stick_arming();
    test_reversed_wide_window();
    test_output_backpressure();
    test_alias_codes();
    test_short_timeout();
    test_arm_on_low_throttle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("PASS rc_arming_failsafe_controller_unit");
    end else begin
      $display("FAIL rc_arming_failsafe_controller_unit");
    end
    $finish;
  end

endmodule
